>>> hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion shorthands, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// Condition holds at every clock edge.
`define ASSERT_HOLDS(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Consequent holds in the same cycle as the antecedent.
`define ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define ASSERT_HOLDS(lbl, cond, msg)
`define ASSERT_SAME(lbl, ante, cons, msg)
`define ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

>>> hw/rtl/vsct_pkg.sv
// ----------------------------------------------------------------------------
// vsct_pkg
// Sizes, codes and helpers shared by the seam cost and trace block.
// ----------------------------------------------------------------------------
package vsct_pkg;

    localparam int MAX_WIDTH  = 512;
    localparam int MAX_HEIGHT = 512;

    localparam int COL_W    = $clog2(MAX_WIDTH);
    localparam int ROW_W    = $clog2(MAX_HEIGHT);
    localparam int DEPTH    = MAX_WIDTH * MAX_HEIGHT;
    localparam int ADDR_W   = $clog2(DEPTH);

    localparam int DIM_W    = 10;
    localparam int IDX_W    = 2;
    localparam int CMD_W    = 1;
    localparam int ENERGY_W = 12;
    localparam int COST_W   = 21;
    localparam int SEAM_W   = 9;
    localparam int KIND_W   = 2;

    localparam logic [COST_W-1:0] COST_MAX  = {COST_W{1'b1}};
    localparam logic [DIM_W-1:0]  DIM_RESET = 10'd512;

    localparam logic [IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
    localparam logic [IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;

    localparam logic [CMD_W-1:0] CMD_SAMPLE = 1'b0;
    localparam logic [CMD_W-1:0] CMD_TRACE  = 1'b1;

    typedef enum logic [KIND_W-1:0] {
        KIND_COST   = 2'd0,
        KIND_SEAM   = 2'd1,
        KIND_REJECT = 2'd2
    } kind_t;

    typedef enum logic [2:0] {
        PH_LOAD  = 3'b001,
        PH_FIRST = 3'b010,
        PH_TRACE = 3'b100
    } phase_t;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_SCAN = 3'b010,
        ST_DONE = 3'b100
    } state_t;

    // Zero reads as one, anything above the limit as the limit.
    function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] dim,
                                                 input logic [DIM_W-1:0] lim);
        logic [DIM_W-1:0] res;
        if (dim == '0)
            res = DIM_W'(1);
        else if (dim > lim)
            res = lim;
        else
            res = dim;
        return res;
    endfunction

    function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] r,
                                                    input logic [COL_W-1:0] c);
        return ADDR_W'(r) * ADDR_W'(MAX_WIDTH) + ADDR_W'(c);
    endfunction

endpackage

>>> hw/rtl/vertical_seam_cost_and_trace.sv
// ----------------------------------------------------------------------------
// vertical_seam_cost_and_trace
// Accumulated seam cost over a raster energy frame, then a bottom-up seam trace.
// ----------------------------------------------------------------------------
// Row-0 samples, the row-0 seam step and rejected commands skip the scan; other
//   words scan n = 1..3 neighbour reads (1 for one column) of the row above,
//   one neighbour read a cycle through the single read port of the cost RAM.
// The result word is registered once the output is free; new words wait for idle.
// Reset: asynchronous, active low; frame 512 x 512, loading at row 0. The cost
//   RAM is not cleared: every entry read belongs to the current frame.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module vertical_seam_cost_and_trace (
    input  logic                           clk,
    input  logic                           rst_n,
    // configuration write port
    input  logic                           cfg_write,
    input  logic [vsct_pkg::IDX_W-1:0]     cfg_index,
    input  logic [vsct_pkg::DIM_W-1:0]     cfg_data,
    // input channel
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [vsct_pkg::CMD_W-1:0]     command,
    input  logic [vsct_pkg::ENERGY_W-1:0]  energy_value,
    // output channel
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [vsct_pkg::KIND_W-1:0]    result_kind,
    output logic [vsct_pkg::COST_W-1:0]    cost_value,
    output logic [vsct_pkg::SEAM_W-1:0]    seam_row,
    output logic [vsct_pkg::SEAM_W-1:0]    seam_column,
    output logic                           seam_last
);

    import vsct_pkg::*;

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    state_t              state_reg,      state_next;
    phase_t              phase_reg,      phase_next;
    logic [DIM_W-1:0]    width_reg,      width_next;
    logic [DIM_W-1:0]    height_reg,     height_next;
    logic [ROW_W-1:0]    load_row_reg,   load_row_next;
    logic [COL_W-1:0]    load_col_reg,   load_col_next;
    logic [COST_W-1:0]   bot_cost_reg,   bot_cost_next;
    logic [COL_W-1:0]    bot_col_reg,    bot_col_next;
    logic [ROW_W-1:0]    trace_row_reg,  trace_row_next;
    logic [COL_W-1:0]    trace_col_reg,  trace_col_next;
    kind_t               job_kind_reg,   job_kind_next;
    logic                issuing_reg,    issuing_next;
    logic                pend_reg,       pend_next;
    logic                have_best_reg,  have_best_next;
    logic                out_valid_reg,  out_valid_next;

    // job payload, no reset
    logic [ENERGY_W-1:0] energy_reg,     energy_next;
    logic [ROW_W-1:0]    emit_row_reg,   emit_row_next;
    logic [COL_W-1:0]    emit_col_reg,   emit_col_next;
    logic [ROW_W-1:0]    scan_row_reg,   scan_row_next;
    logic [COL_W-1:0]    issue_col_reg,  issue_col_next;
    logic [COL_W-1:0]    scan_hi_reg,    scan_hi_next;
    logic [COL_W-1:0]    pend_col_reg,   pend_col_next;
    logic [COST_W-1:0]   best_cost_reg,  best_cost_next;
    logic [COL_W-1:0]    best_col_reg,   best_col_next;
    kind_t               out_kind_reg,   out_kind_next;
    logic [COST_W-1:0]   out_cost_reg,   out_cost_next;
    logic [SEAM_W-1:0]   out_row_reg,    out_row_next;
    logic [SEAM_W-1:0]   out_col_reg,    out_col_next;
    logic                out_last_reg,   out_last_next;

    // ------------------------------------------------------------------
    // Derived values
    // ------------------------------------------------------------------
    logic [DIM_W-1:0]    w_eff;
    logic [DIM_W-1:0]    h_eff;
    logic [ROW_W-1:0]    h_last;
    logic                in_fire;
    logic                done_fire;
    logic                cfg_hit;
    logic                rearm;

    logic [ROW_W-1:0]    win_row;
    logic [COL_W-1:0]    win_col;
    logic [COL_W-1:0]    win_lo;
    logic [COL_W-1:0]    win_hi;
    kind_t               acc_kind;
    logic                acc_scan;

    logic [COST_W:0]     sum_wide;
    logic [COST_W-1:0]   new_cost;
    logic                col_end;
    logic                row_end;
    logic                bot_take;

    logic                ram_wr_en;
    logic [ADDR_W-1:0]   ram_wr_addr;
    logic                ram_rd_en;
    logic [ADDR_W-1:0]   ram_rd_addr;
    logic [COST_W-1:0]   ram_rd_data;

    assign w_eff     = eff_dim(width_reg, DIM_W'(MAX_WIDTH));
    assign h_eff     = eff_dim(height_reg, DIM_W'(MAX_HEIGHT));
    assign h_last    = ROW_W'(h_eff - DIM_W'(1));

    assign in_stall  = (state_reg != ST_IDLE);
    assign in_fire   = in_valid && !in_stall;
    assign done_fire = (state_reg == ST_DONE) && (!out_valid_reg || !out_stall);
    assign cfg_hit   = cfg_write
                       && (cfg_index == REG_FRAME_WIDTH || cfg_index == REG_FRAME_HEIGHT);

    // Window centre for the next word: the load position, or the seam position
    // (bottom minimum on the first trace step).
    always_comb
    begin
        case (phase_reg)
            PH_FIRST:
            begin
                win_row = h_last;
                win_col = bot_col_reg;
            end
            PH_TRACE:
            begin
                win_row = trace_row_reg;
                win_col = trace_col_reg;
            end
            default:
            begin
                win_row = load_row_reg;
                win_col = load_col_reg;
            end
        endcase
    end

    // Clamp the neighbour span c-1..c+1 to the frame.
    assign win_lo = (win_col == '0) ? '0 : win_col - COL_W'(1);
    assign win_hi = ((DIM_W'(win_col) + DIM_W'(1)) < w_eff) ? win_col + COL_W'(1) : win_col;

    always_comb
    begin
        if (command == CMD_SAMPLE)
            acc_kind = (phase_reg == PH_LOAD) ? KIND_COST : KIND_REJECT;
        else
            acc_kind = (phase_reg == PH_LOAD) ? KIND_REJECT : KIND_SEAM;
    end

    // Row 0 has nothing above it to scan.
    assign acc_scan = (acc_kind != KIND_REJECT) && (win_row != '0);

    // Cost of the sample: energy plus the least neighbour above, saturated.
    assign sum_wide = (COST_W+1)'(energy_reg)
                    + ((load_row_reg == '0) ? '0 : (COST_W+1)'(best_cost_reg));
    assign new_cost = (sum_wide > (COST_W+1)'(COST_MAX)) ? COST_MAX : sum_wide[COST_W-1:0];

    assign col_end  = !((DIM_W'(load_col_reg) + DIM_W'(1)) < w_eff);
    assign row_end  = !((DIM_W'(load_row_reg) + DIM_W'(1)) < h_eff);
    // Leftmost minimum of the bottom row: strict less keeps the earlier column.
    assign bot_take = (load_row_reg == h_last)
                      && (load_col_reg == '0 || new_cost < bot_cost_reg);

    assign rearm = cfg_hit
                   || (done_fire && job_kind_reg == KIND_SEAM && emit_row_reg == '0);

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next     = state_reg;
        phase_next     = phase_reg;
        width_next     = width_reg;
        height_next    = height_reg;
        load_row_next  = load_row_reg;
        load_col_next  = load_col_reg;
        bot_cost_next  = bot_cost_reg;
        bot_col_next   = bot_col_reg;
        trace_row_next = trace_row_reg;
        trace_col_next = trace_col_reg;
        job_kind_next  = job_kind_reg;
        issuing_next   = issuing_reg;
        pend_next      = pend_reg;
        have_best_next = have_best_reg;
        out_valid_next = out_valid_reg;
        energy_next    = energy_reg;
        emit_row_next  = emit_row_reg;
        emit_col_next  = emit_col_reg;
        scan_row_next  = scan_row_reg;
        issue_col_next = issue_col_reg;
        scan_hi_next   = scan_hi_reg;
        pend_col_next  = pend_col_reg;
        best_cost_next = best_cost_reg;
        best_col_next  = best_col_reg;
        out_kind_next  = out_kind_reg;
        out_cost_next  = out_cost_reg;
        out_row_next   = out_row_reg;
        out_col_next   = out_col_reg;
        out_last_next  = out_last_reg;

        // Drop the result word once the far side takes it.
        if (!out_stall)
            out_valid_next = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    job_kind_next  = acc_kind;
                    energy_next    = energy_value;
                    emit_row_next  = win_row;
                    emit_col_next  = win_col;
                    scan_row_next  = win_row - ROW_W'(1);
                    issue_col_next = win_lo;
                    scan_hi_next   = win_hi;
                    issuing_next   = 1'b1;
                    pend_next      = 1'b0;
                    have_best_next = 1'b0;
                    state_next     = acc_scan ? ST_SCAN : ST_DONE;
                end
            end

            ST_SCAN:
            begin
                // Issue one neighbour read a cycle; compare the one in flight.
                pend_next = issuing_reg;
                if (issuing_reg)
                begin
                    pend_col_next = issue_col_reg;
                    if (issue_col_reg == scan_hi_reg)
                        issuing_next = 1'b0;
                    else
                        issue_col_next = issue_col_reg + COL_W'(1);
                end
                if (pend_reg)
                begin
                    if (!have_best_reg || ram_rd_data < best_cost_reg)
                    begin
                        best_cost_next = ram_rd_data;
                        best_col_next  = pend_col_reg;
                    end
                    have_best_next = 1'b1;
                    if (!issuing_reg)
                        state_next = ST_DONE;
                end
            end

            ST_DONE:
            begin
                if (done_fire)
                begin
                    out_valid_next = 1'b1;
                    out_kind_next  = job_kind_reg;
                    out_cost_next  = '0;
                    out_row_next   = '0;
                    out_col_next   = '0;
                    out_last_next  = 1'b0;
                    state_next     = ST_IDLE;

                    case (job_kind_reg)
                        KIND_COST:
                        begin
                            out_cost_next = new_cost;
                            if (bot_take)
                            begin
                                bot_cost_next = new_cost;
                                bot_col_next  = load_col_reg;
                            end
                            if (!col_end)
                            begin
                                load_col_next = load_col_reg + COL_W'(1);
                            end
                            else
                            begin
                                load_col_next = '0;
                                if (!row_end)
                                    load_row_next = load_row_reg + ROW_W'(1);
                                else
                                    phase_next = PH_FIRST;
                            end
                        end
                        KIND_SEAM:
                        begin
                            out_row_next   = SEAM_W'(emit_row_reg);
                            out_col_next   = SEAM_W'(emit_col_reg);
                            out_last_next  = (emit_row_reg == '0);
                            trace_row_next = scan_row_reg;
                            trace_col_next = best_col_reg;
                            phase_next     = PH_TRACE;
                        end
                        default:
                        begin
                            // rejected: state untouched
                        end
                    endcase
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (cfg_write && cfg_index == REG_FRAME_WIDTH)
            width_next = cfg_data;
        if (cfg_write && cfg_index == REG_FRAME_HEIGHT)
            height_next = cfg_data;

        // Back to loading at row 0 after the seam ends or the frame changes.
        if (rearm)
        begin
            phase_next     = PH_LOAD;
            load_row_next  = '0;
            load_col_next  = '0;
            bot_cost_next  = '0;
            bot_col_next   = '0;
            trace_row_next = '0;
            trace_col_next = '0;
        end
        if (cfg_hit)
            state_next = ST_IDLE;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            phase_reg     <= PH_LOAD;
            width_reg     <= DIM_RESET;
            height_reg    <= DIM_RESET;
            load_row_reg  <= '0;
            load_col_reg  <= '0;
            bot_cost_reg  <= '0;
            bot_col_reg   <= '0;
            trace_row_reg <= '0;
            trace_col_reg <= '0;
            job_kind_reg  <= KIND_REJECT;
            issuing_reg   <= 1'b0;
            pend_reg      <= 1'b0;
            have_best_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            width_reg     <= width_next;
            height_reg    <= height_next;
            load_row_reg  <= load_row_next;
            load_col_reg  <= load_col_next;
            bot_cost_reg  <= bot_cost_next;
            bot_col_reg   <= bot_col_next;
            trace_row_reg <= trace_row_next;
            trace_col_reg <= trace_col_next;
            job_kind_reg  <= job_kind_next;
            issuing_reg   <= issuing_next;
            pend_reg      <= pend_next;
            have_best_reg <= have_best_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        energy_reg    <= energy_next;
        emit_row_reg  <= emit_row_next;
        emit_col_reg  <= emit_col_next;
        scan_row_reg  <= scan_row_next;
        issue_col_reg <= issue_col_next;
        scan_hi_reg   <= scan_hi_next;
        pend_col_reg  <= pend_col_next;
        best_cost_reg <= best_cost_next;
        best_col_reg  <= best_col_next;
        out_kind_reg  <= out_kind_next;
        out_cost_reg  <= out_cost_next;
        out_row_reg   <= out_row_next;
        out_col_reg   <= out_col_next;
        out_last_reg  <= out_last_next;
    end

    // ------------------------------------------------------------------
    // Cost RAM: write the finished sample, read neighbours of the row above
    // ------------------------------------------------------------------
    assign ram_wr_en   = done_fire && (job_kind_reg == KIND_COST);
    assign ram_wr_addr = cell_addr(load_row_reg, load_col_reg);
    assign ram_rd_en   = (state_reg == ST_SCAN) && issuing_reg;
    assign ram_rd_addr = cell_addr(scan_row_reg, issue_col_reg);

    vsct_ram #(
        .DATA_W (COST_W),
        .ADDR_W (ADDR_W),
        .DEPTH  (DEPTH)
    ) u_cost_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (new_cost),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    // ------------------------------------------------------------------
    // Outputs
    // ------------------------------------------------------------------
    assign out_valid   = out_valid_reg;
    assign result_kind = out_kind_reg;
    assign cost_value  = out_cost_reg;
    assign seam_row    = out_row_reg;
    assign seam_column = out_col_reg;
    assign seam_last   = out_last_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `ASSERT_SAME(a_wr_only_loading, ram_wr_en,
                 state_reg == ST_DONE && phase_reg == PH_LOAD,
                 "cost write outside loading")
    `ASSERT_SAME(a_rd_in_frame, ram_rd_en,
                 DIM_W'(issue_col_reg) < w_eff && issue_col_reg <= scan_hi_reg,
                 "neighbour read outside frame")
    `ASSERT_NEXT(a_last_rearms,
                 done_fire && job_kind_reg == KIND_SEAM && emit_row_reg == '0,
                 phase_reg == PH_LOAD && load_row_reg == '0,
                 "last seam step did not re-arm loading")
    `ASSERT_HOLDS(a_load_in_frame,
                  phase_reg != PH_LOAD
                  || (DIM_W'(load_col_reg) < w_eff && DIM_W'(load_row_reg) < h_eff),
                  "load position outside frame")

endmodule

>>> hw/rtl/vsct_ram.sv
// ----------------------------------------------------------------------------
// vsct_ram
// Simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module vsct_ram #(
    parameter int DATA_W = 21,
    parameter int ADDR_W = 18,
    parameter int DEPTH  = 262144
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem_reg [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule
